[rtl/core/b32d_pkg.sv]
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types, constants and helpers of the base32 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b32d_pkg;

  localparam int unsigned CharW        = 8;
  localparam int unsigned SymW         = 5;
  localparam int unsigned SymsPerGroup = 8;
  localparam int unsigned BytesPerGroup = 5;
  localparam int unsigned AlphabetSize = 32;
  localparam int unsigned AccW         = SymW * (SymsPerGroup - 1);
  localparam int unsigned GroupW       = SymW * SymsPerGroup;
  localparam int unsigned SymCntW      = $clog2(SymsPerGroup);
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 64;
  localparam int unsigned AlphaRegs    = 4;
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned FifoPtrW     = $clog2(FifoDepth);
  localparam int unsigned FifoCntW     = $clog2(FifoDepth + 1);
  localparam int unsigned ByteIdxW     = $clog2(BytesPerGroup);
  localparam int unsigned ShiftW       = $clog2(GroupW + 1);

  localparam logic [CharW-1:0]    PadReset    = 8'd61;
  localparam logic [SymCntW-1:0]  SymCntLast  = SymCntW'(SymsPerGroup - 1);
  localparam logic [ByteIdxW-1:0] ByteIdxLast = ByteIdxW'(BytesPerGroup - 1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgAlpha0  = 3'd0,
    CfgAlpha1  = 3'd1,
    CfgAlpha2  = 3'd2,
    CfgAlpha3  = 3'd3,
    CfgPadChar = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [AlphabetSize-1:0][CharW-1:0] alpha;
    logic [CharW-1:0]                   pad;
  } cfg_t;

  typedef struct packed {
    logic [GroupW-1:0] bits;
    logic              msg_last;
  } grp_t;

  // left-align cnt collected symbols in a 40-bit group, missing symbols zero
  function automatic logic [GroupW-1:0] align_group(input logic [AccW-1:0]    acc,
                                                    input logic [SymCntW-1:0] cnt);
    logic [GroupW-1:0] w;
    logic [ShiftW-1:0] sh;
    w  = {{SymW{1'b0}}, acc};
    sh = ShiftW'(SymW) * (ShiftW'(SymsPerGroup) - ShiftW'(cnt));
    return w << sh;
  endfunction

  // byte idx of a group, most significant first
  function automatic logic [CharW-1:0] group_byte(input logic [GroupW-1:0]   bits,
                                                  input logic [ByteIdxW-1:0] idx);
    logic [CharW-1:0] b;
    b = '0;
    for (int i = 0; i < BytesPerGroup; i++) begin
      if (idx == ByteIdxW'(i)) begin
        b = bits[GroupW-1-CharW*i -: CharW];
      end
    end
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/core/base32_stream_decoder_core.sv]
// ----------------------------------------------------------------------------
// base32_stream_decoder_core
// Streaming base32 decoder with a programmable alphabet and pad character.
// ----------------------------------------------------------------------------
// Input channel: one character per item (in_char_i, end_of_input_i) under
// in_valid_i / in_stall_o. Characters outside the alphabet and pad are dropped.
// Output channel: decoded bytes under out_valid_o / out_stall_i, five bytes per
// group of eight symbols, run_last_o on the fifth byte, message_last_o on the
// last byte of a message. A partial group is flushed on end_of_input_i.
// Path: an item is held in the input register, its group is then written into
// a four-entry group queue, and its first byte is offered from the queue head.
// Throughput: one item per cycle, set by the single classify-and-pack stage;
// the output side drains one byte per cycle unless out_stall_i is high, and
// the input stalls only when the group queue is full.
// When the receiver stalls, bytes hold and the queue fills, then in_stall_o
// rises. Reset clears the queue, the accumulator and the alphabet, and sets
// the pad character to '='. Configuration writes take effect at the next edge;
// the user must make them while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module base32_stream_decoder_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [b32d_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [b32d_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [b32d_pkg::CharW-1:0]      in_char_i,
  input  wire logic                            end_of_input_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [b32d_pkg::CharW-1:0]           out_byte_o,
  output logic                                 run_last_o,
  output logic                                 message_last_o
);

  b32d_pkg::cfg_t cfg;
  b32d_pkg::grp_t push_grp;
  logic           push;
  logic           fifo_full;

  b32d_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  b32d_pack u_pack (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_char_i      (in_char_i),
    .end_of_input_i (end_of_input_i),
    .fifo_full_i    (fifo_full),
    .push_o         (push),
    .push_grp_o     (push_grp)
  );

  b32d_serializer u_serializer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .push_grp_i     (push_grp),
    .fifo_full_o    (fifo_full),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .run_last_o     (run_last_o),
    .message_last_o (message_last_o)
  );

endmodule

`default_nettype wire

[rtl/core/b32d_cfg_regs.sv]
// ----------------------------------------------------------------------------
// b32d_cfg_regs
// Alphabet and pad character registers with a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module b32d_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [b32d_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [b32d_pkg::CfgDataW-1:0]   cfg_data_i,
  output b32d_pkg::cfg_t                       cfg_o
);

  logic [b32d_pkg::AlphaRegs-1:0][b32d_pkg::CfgDataW-1:0] alpha_q;
  logic [b32d_pkg::CharW-1:0]                             pad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= '0;
      pad_q   <= b32d_pkg::PadReset;
    end else if (cfg_we_i) begin
      unique case (b32d_pkg::cfg_idx_e'(cfg_idx_i))
        b32d_pkg::CfgAlpha0:  alpha_q[0] <= cfg_data_i;
        b32d_pkg::CfgAlpha1:  alpha_q[1] <= cfg_data_i;
        b32d_pkg::CfgAlpha2:  alpha_q[2] <= cfg_data_i;
        b32d_pkg::CfgAlpha3:  alpha_q[3] <= cfg_data_i;
        b32d_pkg::CfgPadChar: pad_q      <= cfg_data_i[b32d_pkg::CharW-1:0];
        default: ;
      endcase
    end
  end

  // symbol k sits in byte k of the flattened registers
  assign cfg_o.alpha = alpha_q;
  assign cfg_o.pad   = pad_q;

endmodule

`default_nettype wire

[rtl/core/b32d_classify.sv]
// ----------------------------------------------------------------------------
// b32d_classify
// Maps one character to its symbol value, or flags it as not a symbol.
// ----------------------------------------------------------------------------
`default_nettype none

module b32d_classify (
  input  wire b32d_pkg::cfg_t               cfg_i,
  input  wire logic [b32d_pkg::CharW-1:0]   char_i,
  output logic                              hit_o,
  output logic [b32d_pkg::SymW-1:0]         sym_o
);

  always_comb begin
    hit_o = 1'b0;
    sym_o = '0;
    // ascending scan so the highest matching index wins
    for (int k = 0; k < b32d_pkg::AlphabetSize; k++) begin
      if (cfg_i.alpha[k] != '0 && cfg_i.alpha[k] == char_i) begin
        hit_o = 1'b1;
        sym_o = b32d_pkg::SymW'(k);
      end
    end
    // pad takes precedence and decodes as zero
    if (cfg_i.pad != '0 && char_i == cfg_i.pad) begin
      hit_o = 1'b1;
      sym_o = '0;
    end
  end

endmodule

`default_nettype wire

[rtl/core/b32d_pack.sv]
// ----------------------------------------------------------------------------
// b32d_pack
// Input register, symbol accumulator and group push toward the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module b32d_pack (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire b32d_pkg::cfg_t               cfg_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [b32d_pkg::CharW-1:0]   in_char_i,
  input  wire logic                         end_of_input_i,
  input  wire logic                         fifo_full_i,
  output logic                              push_o,
  output b32d_pkg::grp_t                    push_grp_o
);

  logic                             vld_q;
  logic [b32d_pkg::CharW-1:0]       char_q;
  logic                             eoi_q;
  logic [b32d_pkg::AccW-1:0]        acc_q, acc_d;
  logic [b32d_pkg::SymCntW-1:0]     cnt_q, cnt_d;
  logic                             advance;
  logic                             accept;
  logic                             work;
  logic                             hit;
  logic [b32d_pkg::SymW-1:0]        sym;
  logic [b32d_pkg::GroupW-1:0]      acc_wide;
  logic                             full_grp;

  b32d_classify u_classify (
    .cfg_i  (cfg_i),
    .char_i (char_q),
    .hit_o  (hit),
    .sym_o  (sym)
  );

  // the held item moves on only if the queue has room for its group
  assign advance    = !vld_q || !fifo_full_i;
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;
  assign work       = vld_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (advance) begin
      vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= in_char_i;
      eoi_q  <= end_of_input_i;
    end
  end

  assign acc_wide = {acc_q, sym};
  assign full_grp = hit && cnt_q == b32d_pkg::SymCntLast;

  always_comb begin
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    push_o     = 1'b0;
    push_grp_o = '0;
    if (work) begin
      if (full_grp) begin
        push_o              = 1'b1;
        push_grp_o.bits     = acc_wide;
        push_grp_o.msg_last = eoi_q;
        acc_d               = '0;
        cnt_d               = '0;
      end else if (hit) begin
        acc_d = acc_wide[b32d_pkg::AccW-1:0];
        cnt_d = cnt_q + 1'b1;
      end
      // flush a partial group at end of message
      if (eoi_q && cnt_d != '0) begin
        push_o              = 1'b1;
        push_grp_o.bits     = b32d_pkg::align_group(acc_d, cnt_d);
        push_grp_o.msg_last = 1'b1;
        acc_d               = '0;
        cnt_d               = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/b32d_serializer.sv]
// ----------------------------------------------------------------------------
// b32d_serializer
// Group queue and byte serializer, five bytes per group.
// ----------------------------------------------------------------------------
`default_nettype none

module b32d_serializer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire b32d_pkg::grp_t               push_grp_i,
  output logic                              fifo_full_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [b32d_pkg::CharW-1:0]        out_byte_o,
  output logic                              run_last_o,
  output logic                              message_last_o
);

  b32d_pkg::grp_t                   mem_q [b32d_pkg::FifoDepth];
  logic [b32d_pkg::FifoPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [b32d_pkg::FifoCntW-1:0]    cnt_q;
  logic [b32d_pkg::ByteIdxW-1:0]    idx_q;
  logic                             out_take;
  logic                             last_byte;
  logic                             pop;
  b32d_pkg::grp_t                   head;

  assign head        = mem_q[rd_ptr_q];
  assign fifo_full_o = cnt_q == b32d_pkg::FifoCntW'(b32d_pkg::FifoDepth);
  assign out_valid_o = cnt_q != '0;
  assign last_byte   = idx_q == b32d_pkg::ByteIdxLast;
  assign out_take    = out_valid_o && !out_stall_i;
  assign pop         = out_take && last_byte;

  assign out_byte_o     = b32d_pkg::group_byte(head.bits, idx_q);
  assign run_last_o     = last_byte;
  assign message_last_o = last_byte && head.msg_last;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (out_take) begin
        idx_q <= last_byte ? '0 : idx_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
